// ===== rtl/core/dnle_pkg.sv =====
package dnle_pkg;

  // byte and label length widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 6;

  // default label buffer depth
  localparam int unsigned LABEL_MAX_DEF = 62;

  // special characters
  localparam logic [BYTE_W-1:0] CH_DOT = 8'd46;
  localparam logic [BYTE_W-1:0] CH_END = 8'd0;

  // name phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_IN    = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;

endpackage

// ===== rtl/core/dnle_label_mem.sv =====
module dnle_label_mem #(
  parameter int unsigned DEPTH  = dnle_pkg::LABEL_MAX_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [dnle_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [dnle_pkg::BYTE_W-1:0] rdata_o
);

  logic [dnle_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [dnle_pkg::BYTE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dns_name_label_encoder_unit.sv =====
// a character that is only stored is written to the label memory; a dot or end character is
// followed by its wire bytes at one byte per cycle from the output register unless the output
// stalls; a label of n bytes goes out as its length byte and its n data bytes, plus a terminator,
// paced by the label memory read port and the single output register; input is held meanwhile
// reset: control state, label length and output valid clear at once; the label memory is not cleared
module dns_name_label_encoder_unit #(
  parameter int unsigned LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dnle_pkg::BYTE_W-1:0] name_char_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dnle_pkg::BYTE_W-1:0] wire_byte_o,
  output logic                        name_done_o,
  output logic                        label_overflow_o
);

  localparam int unsigned IdxW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int unsigned LW   = dnle_pkg::LEN_W;
  localparam int unsigned BW   = dnle_pkg::BYTE_W;

  // sequencer state codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLen  = 2'd1;
  localparam logic [1:0] StData = 2'd2;
  localparam logic [1:0] StTerm = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [1:0]      phase_q, phase_d;
  logic [LW-1:0]   len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            term_q, term_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            out_valid_q, out_valid_d;
  logic [BW-1:0]   wire_byte_q, wire_byte_d;
  logic            done_q, done_d;
  logic            lovf_q, lovf_d;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [BW-1:0]   mem_rdata;

  logic            accept;
  logic            out_free;
  logic            is_end, is_dot;
  logic            data_last;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_end    = (name_char_i == dnle_pkg::CH_END);
  assign is_dot    = (name_char_i == dnle_pkg::CH_DOT);
  assign data_last = ((LW'(idx_q) + 1'b1) == len_q);
  assign mem_waddr = len_q[IdxW-1:0];

  dnle_label_mem #(
    .DEPTH  (LABEL_MAX),
    .ADDR_W (IdxW)
  ) u_label_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (name_char_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // phase tracking, label buffering and flush sequencing
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    term_d      = term_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    wire_byte_d = wire_byte_q;
    done_d      = done_q;
    lovf_d      = lovf_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (phase_q)
            dnle_pkg::PH_SKIP: begin
              if (is_end) begin
                phase_d = dnle_pkg::PH_START;
              end
            end
            dnle_pkg::PH_IN: begin
              if (is_end) begin
                phase_d = dnle_pkg::PH_START;
                term_d  = 1'b1;
                state_d = ((len_q != '0) || ovf_q) ? StLen : StTerm;
              end else if (is_dot) begin
                term_d  = 1'b0;
                state_d = StLen;
              end else if (len_q < LW'(LABEL_MAX)) begin
                mem_we = 1'b1;
                len_d  = len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            default: begin
              // start of name, including the unused code
              len_d = '0;
              ovf_d = 1'b0;
              if (is_end) begin
                phase_d = dnle_pkg::PH_START;
                state_d = StTerm;
              end else if (is_dot) begin
                phase_d = dnle_pkg::PH_SKIP;
                state_d = StTerm;
              end else begin
                mem_we  = 1'b1;
                len_d   = LW'(1);
                phase_d = dnle_pkg::PH_IN;
              end
            end
          endcase
        end
      end
      StLen: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          wire_byte_d = BW'(len_q);
          done_d      = 1'b0;
          lovf_d      = ovf_q;
          if (len_q != '0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            idx_d     = '0;
            state_d   = StData;
          end else begin
            ovf_d   = 1'b0;
            state_d = term_q ? StTerm : StIdle;
          end
        end
      end
      StData: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          wire_byte_d = mem_rdata;
          done_d      = 1'b0;
          lovf_d      = ovf_q;
          if (data_last) begin
            len_d   = '0;
            ovf_d   = 1'b0;
            state_d = term_q ? StTerm : StIdle;
          end else begin
            // fetch the next byte while this one goes out
            mem_re    = 1'b1;
            mem_raddr = idx_q + 1'b1;
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      StTerm: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          wire_byte_d = dnle_pkg::CH_END;
          done_d      = 1'b1;
          lovf_d      = 1'b0;
          len_d       = '0;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= dnle_pkg::PH_START;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      term_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      term_q      <= term_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    wire_byte_q <= wire_byte_d;
    done_q      <= done_d;
    lovf_q      <= lovf_d;
  end

  assign in_stall_o       = (state_q != StIdle);
  assign out_valid_o      = out_valid_q;
  assign wire_byte_o      = wire_byte_q;
  assign name_done_o      = done_q;
  assign label_overflow_o = lovf_q;

  // label length never exceeds the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(LABEL_MAX))
    else $error("label length beyond buffer depth");

  // the read index stays inside the current label while flushing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StData) |-> (LW'(idx_q) < len_q))
    else $error("flush index outside label");

  // a terminator is a zero byte and never carries the overflow mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && name_done_o) |-> (wire_byte_o == dnle_pkg::CH_END && !label_overflow_o))
    else $error("malformed terminator");

  // the label memory is never written during a flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StIdle))
    else $error("label write during flush");

endmodule
